FILE: rtl/kwm_pkg.sv
package kwm_pkg;

    localparam int NUM_LISTS_DEF   = 4;
    localparam int LIST_DEPTH_DEF  = 16;
    localparam int VALUE_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_list_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_list_sts;

endpackage

FILE: rtl/kwm_list.sv
module kwm_list #(
    parameter int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEF,
    parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  kwm_pkg::t_list_ctl     i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output kwm_pkg::t_list_sts     o_sts,
    output logic [VALUE_WIDTH-1:0] o_head
);
    import kwm_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(LIST_DEPTH - 1);

    logic [VALUE_WIDTH-1:0] r_mem [LIST_DEPTH];
    logic [VALUE_WIDTH-1:0] r_head;
    logic [AW-1:0]          r_wr_idx, n_wr_idx;
    logic                   r_wr_wrap, n_wr_wrap;
    logic [AW-1:0]          r_rd_idx, n_rd_idx;
    logic                   r_rd_wrap, n_rd_wrap;
    logic                   wr_en;

    assign wr_en = i_ctl.push & ~i_ctl.clear;

    always_comb begin
        n_wr_idx  = r_wr_idx;
        n_wr_wrap = r_wr_wrap;
        n_rd_idx  = r_rd_idx;
        n_rd_wrap = r_rd_wrap;
        if (i_ctl.clear) begin
            n_wr_idx  = '0;
            n_wr_wrap = 1'b0;
            n_rd_idx  = '0;
            n_rd_wrap = 1'b0;
        end else begin
            if (i_ctl.push) begin
                if (r_wr_idx == LAST_IDX) begin
                    n_wr_idx  = '0;
                    n_wr_wrap = ~r_wr_wrap;
                end else begin
                    n_wr_idx = r_wr_idx + 1'b1;
                end
            end
            if (i_ctl.pop) begin
                if (r_rd_idx == LAST_IDX) begin
                    n_rd_idx  = '0;
                    n_rd_wrap = ~r_rd_wrap;
                end else begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx  <= '0;
            r_wr_wrap <= 1'b0;
            r_rd_idx  <= '0;
            r_rd_wrap <= 1'b0;
        end else begin
            r_wr_idx  <= n_wr_idx;
            r_wr_wrap <= n_wr_wrap;
            r_rd_idx  <= n_rd_idx;
            r_rd_wrap <= n_rd_wrap;
        end
    end

    // head always mirrors the entry at the read pointer; bypass a write to it
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_idx] <= i_value;
        end
        if (wr_en && (r_wr_idx == n_rd_idx)) begin
            r_head <= i_value;
        end else begin
            r_head <= r_mem[n_rd_idx];
        end
    end

    assign o_sts.full  = (r_wr_idx == r_rd_idx) && (r_wr_wrap != r_rd_wrap);
    assign o_sts.empty = (r_wr_idx == r_rd_idx) && (r_wr_wrap == r_rd_wrap);
    assign o_head      = r_head;

endmodule

FILE: rtl/k_way_sorted_merge_top.sv
// K-way merge of sorted lists.
// Command channel: drive i_kind, i_list_select and i_element_value with
// start high; the command transfers at a rising edge where busy is low.
// busy stays low, so one command transfers in every cycle.
// Commands: push appends a value to the named list, pop removes the
// smallest head over all non-empty lists (lower list wins ties), clear
// empties every list.
// Every command gives exactly one result, shown on o_result_value,
// o_source_list and o_status for a single cycle with o_strobe high, in the
// cycle after the command transfers (throughput 1 per cycle).
// Heads are kept in per-list registers that follow each list's memory
// read port, so a pop is a compare tree over the heads and one register.
// Status: ok, push refused because the list is full or does not exist,
// or pop with all lists empty. Value and source are zero unless a pop
// succeeds.
// Reset empties all lists and drops any pending strobe; list contents
// are not cleared. The receiver cannot stall: each result must be taken
// in the cycle it is shown.
module k_way_sorted_merge_top #(
    parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEF,
    parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_kind,
    input  logic [$clog2(NUM_LISTS)-1:0]         i_list_select,
    input  logic signed [VALUE_WIDTH-1:0]        i_element_value,
    output logic                                 o_strobe,
    output logic signed [VALUE_WIDTH-1:0]        o_result_value,
    output logic [$clog2(NUM_LISTS)-1:0]         o_source_list,
    output kwm_pkg::t_status                     o_status
);
    import kwm_pkg::*;

    localparam int SEL_W = $clog2(NUM_LISTS);
    localparam int LEAVES = 1 << SEL_W;
    localparam int NODES  = 2 * LEAVES - 1;

    t_list_ctl                 list_ctl  [NUM_LISTS];
    t_list_sts                 list_sts  [NUM_LISTS];
    logic [VALUE_WIDTH-1:0]    list_head [NUM_LISTS];

    logic                      node_vld [NODES];
    logic signed [VALUE_WIDTH-1:0] node_key [NODES];
    logic [SEL_W-1:0]          node_idx [NODES];

    t_kind                     kind;
    logic                      accept;
    logic                      sel_full;
    logic                      sel_ok;

    logic                      r_strobe;
    logic signed [VALUE_WIDTH-1:0] r_value, n_value;
    logic [SEL_W-1:0]          r_source, n_source;
    t_status                   r_status, n_status;

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign kind   = t_kind'(i_kind);
    assign sel_ok = ({1'b0, i_list_select} < (SEL_W + 1)'(NUM_LISTS));

    for (genvar g = 0; g < NUM_LISTS; g++) begin : g_list
        kwm_list #(
            .LIST_DEPTH  (LIST_DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_list (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (list_ctl[g]),
            .i_value (i_element_value),
            .o_sts   (list_sts[g]),
            .o_head  (list_head[g])
        );
    end

    // tournament over the heads; left subtree holds the lower lists
    always_comb begin
        for (int i = 0; i < LEAVES; i++) begin
            if (i < NUM_LISTS) begin
                node_vld[LEAVES-1+i] = ~list_sts[i].empty;
                node_key[LEAVES-1+i] = list_head[i];
            end else begin
                node_vld[LEAVES-1+i] = 1'b0;
                node_key[LEAVES-1+i] = '0;
            end
            node_idx[LEAVES-1+i] = SEL_W'(i);
        end
        for (int n = LEAVES - 2; n >= 0; n--) begin
            if (node_vld[2*n+1] &&
                (!node_vld[2*n+2] || (node_key[2*n+1] <= node_key[2*n+2]))) begin
                node_vld[n] = 1'b1;
                node_key[n] = node_key[2*n+1];
                node_idx[n] = node_idx[2*n+1];
            end else begin
                node_vld[n] = node_vld[2*n+2];
                node_key[n] = node_key[2*n+2];
                node_idx[n] = node_idx[2*n+2];
            end
        end
    end

    always_comb begin
        sel_full = 1'b0;
        for (int i = 0; i < NUM_LISTS; i++) begin
            if (i_list_select == SEL_W'(i)) begin
                sel_full = list_sts[i].full;
            end
        end
    end

    always_comb begin
        n_value  = '0;
        n_source = '0;
        n_status = ST_OK;
        for (int i = 0; i < NUM_LISTS; i++) begin
            list_ctl[i] = '0;
        end
        if (accept) begin
            case (kind)
                KIND_PUSH: begin
                    if (!sel_ok || sel_full) begin
                        n_status = ST_FULL;
                    end else begin
                        for (int i = 0; i < NUM_LISTS; i++) begin
                            list_ctl[i].push = (i_list_select == SEL_W'(i));
                        end
                    end
                end
                KIND_POP: begin
                    if (!node_vld[0]) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_value  = node_key[0];
                        n_source = node_idx[0];
                        for (int i = 0; i < NUM_LISTS; i++) begin
                            list_ctl[i].pop = (node_idx[0] == SEL_W'(i));
                        end
                    end
                end
                KIND_CLEAR: begin
                    for (int i = 0; i < NUM_LISTS; i++) begin
                        list_ctl[i].clear = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_source <= n_source;
        r_status <= n_status;
    end

    assign o_strobe       = r_strobe;
    assign o_result_value = r_value;
    assign o_source_list  = r_source;
    assign o_status       = r_status;

endmodule
